@@ sv/tcct_pkg.sv @@
// Package for the text console cursor tracker.
// Holds the command, action and line-break codes and the payload structs.
// No dependencies.
package tcct_pkg;

    localparam int COORD_BITS_DEF = 8;
    localparam int SIZE_BITS      = 8;
    localparam int CFG_IDX_BITS   = 2;

    localparam logic [SIZE_BITS-1:0] COLUMNS_RESET = 8'd80;
    localparam logic [SIZE_BITS-1:0] ROWS_RESET    = 8'd25;

    typedef enum logic [2:0] {
        CMD_GLYPH   = 3'd0,
        CMD_NEWLINE = 3'd1,
        CMD_CR      = 3'd2,
        CMD_BS      = 3'd3,
        CMD_SET     = 3'd4,
        CMD_CLEAR   = 3'd5
    } cmd_e_t;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_DRAW  = 2'd1,
        ACT_CLEAR = 2'd2
    } action_e_t;

    typedef enum logic [1:0] {
        LB_NONE = 2'd0,
        LB_SOFT = 2'd1,
        LB_HARD = 2'd2
    } nl_kind_e_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_COLUMNS = 2'd0,
        REG_ROWS    = 2'd1
    } cfg_reg_e_t;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] glyph_in;
        logic [7:0] target_column;
        logic [7:0] target_row;
    } cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] cell_column;
        logic [7:0] cell_row;
        logic [7:0] glyph_out;
        logic       scroll;
        logic [1:0] nl_kind;
        logic [7:0] nl_row;
    } upd_t;

endpackage

@@ sv/tcct_if.sv @@
// Valid/ready channel interfaces for commands and console updates.
// Depends on nothing; payload fields follow tcct_pkg structs.
interface tcct_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [7:0] glyph_in;
    logic [7:0] target_column;
    logic [7:0] target_row;

    modport source (output valid, command, glyph_in, target_column, target_row,
                    input ready);
    modport sink   (input valid, command, glyph_in, target_column, target_row,
                    output ready);
endinterface

interface tcct_upd_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] cell_column;
    logic [7:0] cell_row;
    logic [7:0] glyph_out;
    logic       scroll;
    logic [1:0] nl_kind;
    logic [7:0] nl_row;

    modport source (output valid, action, cell_column, cell_row, glyph_out, scroll,
                    nl_kind, nl_row, input ready);
    modport sink   (input valid, action, cell_column, cell_row, glyph_out, scroll,
                    nl_kind, nl_row, output ready);
endinterface

@@ sv/tcct_step.sv @@
// Command decode and cursor update logic for one command.
// Depends on tcct_pkg.
module tcct_step #(
    parameter int COORD_BITS = tcct_pkg::COORD_BITS_DEF
) (
    input  tcct_pkg::cmd_t        cmd_in,
    input  logic [7:0]            columns,
    input  logic [7:0]            rows,
    input  logic [COORD_BITS-1:0] col,
    input  logic [COORD_BITS-1:0] row,
    output logic [COORD_BITS-1:0] col_next,
    output logic [COORD_BITS-1:0] row_next,
    output tcct_pkg::upd_t        upd
);

    localparam int W = ((COORD_BITS > 8) ? COORD_BITS : 8) + 1;

    logic                  console_ready;
    logic [COORD_BITS-1:0] col_inc;
    logic [COORD_BITS-1:0] col_dec;
    logic [COORD_BITS-1:0] row_inc;
    logic [COORD_BITS-1:0] row_nl;
    logic [W-1:0]          col_w;
    logic [W-1:0]          row_w;
    logic [W-1:0]          col_dec_w;
    logic [W-1:0]          row_nl_w;
    logic [W-1:0]          row_inc_w;
    logic [W-1:0]          cols_w;
    logic [W-1:0]          rows_w;
    logic [W-1:0]          set_col_w;
    logic [W-1:0]          set_row_w;
    logic                  wrap;
    logic                  last_row;

    assign console_ready = (columns != 8'd0) && (rows != 8'd0);
    assign cols_w    = W'(columns);
    assign rows_w    = W'(rows);
    assign col_w     = W'(col);
    assign row_w     = W'(row);
    assign col_inc   = col + COORD_BITS'(1);
    assign col_dec   = col - COORD_BITS'(1);
    assign row_inc   = row + COORD_BITS'(1);
    assign col_dec_w = W'(col_dec);
    assign row_inc_w = row_w + W'(1);
    assign last_row  = row_inc_w >= rows_w;
    assign row_nl    = last_row ? row : row_inc;
    assign row_nl_w  = W'(row_nl);
    assign wrap      = (W'(col_inc) >= cols_w) || (col_inc == '0);
    assign set_col_w = (W'(cmd_in.target_column) < cols_w) ? W'(cmd_in.target_column)
                                                            : cols_w - W'(1);
    assign set_row_w = (W'(cmd_in.target_row) < rows_w) ? W'(cmd_in.target_row)
                                                       : rows_w - W'(1);

    always_comb
    begin
        upd      = '0;
        col_next = col;
        row_next = row;
        unique case (cmd_in.command)
            tcct_pkg::CMD_GLYPH:
            begin
                if (console_ready)
                begin
                    upd.action      = tcct_pkg::ACT_DRAW;
                    upd.cell_column = col_w[7:0];
                    upd.cell_row    = row_w[7:0];
                    upd.glyph_out   = cmd_in.glyph_in;
                    if (wrap)
                    begin
                        col_next    = '0;
                        row_next    = row_nl;
                        upd.scroll  = last_row;
                        upd.nl_kind = tcct_pkg::LB_SOFT;
                        upd.nl_row  = row_nl_w[7:0];
                    end
                    else
                    begin
                        col_next = col_inc;
                    end
                end
            end
            tcct_pkg::CMD_NEWLINE:
            begin
                if (console_ready)
                begin
                    col_next    = '0;
                    row_next    = row_nl;
                    upd.scroll  = last_row;
                    upd.nl_kind = tcct_pkg::LB_HARD;
                    upd.nl_row  = row_nl_w[7:0];
                end
            end
            tcct_pkg::CMD_CR:
            begin
                if (console_ready)
                begin
                    col_next = '0;
                end
            end
            tcct_pkg::CMD_BS:
            begin
                if (console_ready && (col != '0))
                begin
                    col_next        = col_dec;
                    upd.action      = tcct_pkg::ACT_CLEAR;
                    upd.cell_column = col_dec_w[7:0];
                    upd.cell_row    = row_w[7:0];
                end
            end
            tcct_pkg::CMD_SET:
            begin
                if (console_ready)
                begin
                    col_next = set_col_w[COORD_BITS-1:0];
                    row_next = set_row_w[COORD_BITS-1:0];
                end
                else
                begin
                    col_next = '0;
                    row_next = '0;
                end
            end
            tcct_pkg::CMD_CLEAR:
            begin
                col_next = '0;
                row_next = '0;
            end
            default:
            begin
                col_next = col;
                row_next = row;
            end
        endcase
    end

endmodule

@@ sv/text_console_cursor_tracker_top.sv @@
// Text console cursor tracker, top level.
// Update valid is registered: it rises in the cycle after a command transaction.
// Throughput: one command per cycle while updates are taken; the update register frees as it is taken.
// Reset: sizes return to 80 columns by 25 rows, cursor to (0,0), no update held.
// Depends on tcct_pkg, tcct_if and tcct_step.
module text_console_cursor_tracker_top #(
    parameter int COORD_BITS = tcct_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tcct_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [tcct_pkg::SIZE_BITS-1:0]    cfg_wdata,
    tcct_cmd_if.sink                          cmd,
    tcct_upd_if.source                        upd
);

    localparam int W = ((COORD_BITS > 8) ? COORD_BITS : 8) + 1;

    logic [7:0]            columns_reg;
    logic [7:0]            rows_reg;
    logic [COORD_BITS-1:0] col_reg;
    logic [COORD_BITS-1:0] row_reg;
    logic [COORD_BITS-1:0] col_next;
    logic [COORD_BITS-1:0] row_next;
    logic                  out_valid_reg;
    tcct_pkg::upd_t        upd_reg;
    tcct_pkg::upd_t        upd_next;
    tcct_pkg::cmd_t        cmd_in;
    logic                  cmd_accept;

    assign cmd_in.command       = cmd.command;
    assign cmd_in.glyph_in      = cmd.glyph_in;
    assign cmd_in.target_column = cmd.target_column;
    assign cmd_in.target_row    = cmd.target_row;

    assign cmd.ready  = !out_valid_reg || upd.ready;
    assign cmd_accept = cmd.valid && cmd.ready;

    tcct_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .cmd_in   (cmd_in),
        .columns  (columns_reg),
        .rows     (rows_reg),
        .col      (col_reg),
        .row      (row_reg),
        .col_next (col_next),
        .row_next (row_next),
        .upd      (upd_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg   <= tcct_pkg::COLUMNS_RESET;
            rows_reg      <= tcct_pkg::ROWS_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == tcct_pkg::REG_COLUMNS ||
                           cfg_index == tcct_pkg::REG_ROWS))
            begin
                if (cfg_index == tcct_pkg::REG_COLUMNS)
                begin
                    columns_reg <= cfg_wdata;
                end
                else
                begin
                    rows_reg <= cfg_wdata;
                end
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (cmd_accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end

            if (cmd_accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (upd.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            upd_reg <= upd_next;
        end
    end

    assign upd.valid       = out_valid_reg;
    assign upd.action      = upd_reg.action;
    assign upd.cell_column = upd_reg.cell_column;
    assign upd.cell_row    = upd_reg.cell_row;
    assign upd.glyph_out   = upd_reg.glyph_out;
    assign upd.scroll      = upd_reg.scroll;
    assign upd.nl_kind     = upd_reg.nl_kind;
    assign upd.nl_row      = upd_reg.nl_row;

    // cursor stays inside the console whenever the size is nonzero
    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (columns_reg != 8'd0) |-> (W'(col_reg) < W'(columns_reg)))
        else $error("cursor column outside console");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rows_reg != 8'd0) |-> (W'(row_reg) < W'(rows_reg)))
        else $error("cursor row outside console");

    a_accept_gives_update: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_accept |=> upd.valid)
        else $error("command transaction without update");

    a_no_action_zero_cell: assert property (@(posedge clk) disable iff (!rst_n)
        (upd.valid && upd.action == tcct_pkg::ACT_NONE) |->
        (upd.cell_column == 8'd0 && upd.cell_row == 8'd0 && upd.glyph_out == 8'd0))
        else $error("cell fields set with no action");

    a_scroll_has_break: assert property (@(posedge clk) disable iff (!rst_n)
        (upd.valid && upd.scroll) |-> (upd.nl_kind != tcct_pkg::LB_NONE))
        else $error("scroll without line break");

endmodule

@@ tb/tb_text_console_cursor_tracker_top.sv @@
// Testbench for text_console_cursor_tracker_top: directed and random command traffic.
// Predicts every console update and checks it field by field.
// Depends on tcct_pkg, tcct_if and the tracker RTL.
module tb_text_console_cursor_tracker_top;

    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [tcct_pkg::CFG_IDX_BITS-1:0] cfg_index;
    logic [tcct_pkg::SIZE_BITS-1:0] cfg_wdata;

    tcct_cmd_if cmd_ch();
    tcct_upd_if upd_ch();

    text_console_cursor_tracker_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_ch),
        .upd       (upd_ch)
    );

    // predicted console state
    logic [7:0] pred_cols;
    logic [7:0] pred_rows;
    logic [7:0] pred_col;
    logic [7:0] pred_row;

    tcct_pkg::upd_t pending_updates[$];
    int unsigned mismatch_count;
    bit tx_idle;
    bit rx_idle;
    int hold_cycles;

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("%0t: %s got %0d want %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic void next_line(output logic scr, output logic [7:0] row_after);
        pred_col = '0;
        if ({1'b0, pred_row} + 9'd1 >= {1'b0, pred_rows})
        begin
            scr = 1'b1;
        end
        else
        begin
            scr = 1'b0;
            pred_row = pred_row + 8'd1;
        end
        row_after = pred_row;
    endfunction

    function automatic tcct_pkg::upd_t console_next(input logic [2:0] op,
                                                    input logic [7:0] g,
                                                    input logic [7:0] tc,
                                                    input logic [7:0] tr);
        tcct_pkg::upd_t u;
        logic scr;
        logic [7:0] row_after;
        logic ready_now;
        u = '0;
        ready_now = (pred_cols != 8'd0) && (pred_rows != 8'd0);
        case (op)
            tcct_pkg::CMD_GLYPH:
            begin
                if (ready_now)
                begin
                    u.action = tcct_pkg::ACT_DRAW;
                    u.cell_column = pred_col;
                    u.cell_row = pred_row;
                    u.glyph_out = g;
                    pred_col = pred_col + 8'd1;
                    if (pred_col >= pred_cols || pred_col == 8'd0)
                    begin
                        next_line(scr, row_after);
                        u.scroll = scr;
                        u.nl_kind = tcct_pkg::LB_SOFT;
                        u.nl_row = row_after;
                    end
                end
            end
            tcct_pkg::CMD_NEWLINE:
            begin
                if (ready_now)
                begin
                    next_line(scr, row_after);
                    u.scroll = scr;
                    u.nl_kind = tcct_pkg::LB_HARD;
                    u.nl_row = row_after;
                end
            end
            tcct_pkg::CMD_CR:
            begin
                if (ready_now)
                    pred_col = '0;
            end
            tcct_pkg::CMD_BS:
            begin
                if (ready_now && pred_col != 8'd0)
                begin
                    pred_col = pred_col - 8'd1;
                    u.action = tcct_pkg::ACT_CLEAR;
                    u.cell_column = pred_col;
                    u.cell_row = pred_row;
                end
            end
            tcct_pkg::CMD_SET:
            begin
                if (ready_now)
                begin
                    pred_col = (tc < pred_cols) ? tc : pred_cols - 8'd1;
                    pred_row = (tr < pred_rows) ? tr : pred_rows - 8'd1;
                end
                else
                begin
                    pred_col = '0;
                    pred_row = '0;
                end
            end
            tcct_pkg::CMD_CLEAR:
            begin
                pred_col = '0;
                pred_row = '0;
            end
            default:
            begin
            end
        endcase
        return u;
    endfunction

    task automatic send_cmd(input logic [2:0] op, input logic [7:0] g,
                            input logic [7:0] tc, input logic [7:0] tr);
        int gap;
        gap = tx_idle ? $urandom_range(0, 11) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.command <= op;
        cmd_ch.glyph_in <= g;
        cmd_ch.target_column <= tc;
        cmd_ch.target_row <= tr;
        do @(posedge clk); while (!cmd_ch.ready);
        pending_updates.push_back(console_next(op, g, tc, tr));
    endtask

    task automatic drain_updates();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (pending_updates.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic cfg_write(input tcct_pkg::cfg_reg_e_t idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == tcct_pkg::REG_COLUMNS)
            pred_cols = val;
        else
            pred_rows = val;
        pred_col = '0;
        pred_row = '0;
    endtask

    // 80 x 25 after reset: every command, wrap and scroll at the bottom corner
    task automatic test_default_size();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_cmd(tcct_pkg::CMD_GLYPH, 8'h00, 8'h00, 8'h00);
        send_cmd(tcct_pkg::CMD_GLYPH, 8'hFF, 8'hFF, 8'hFF);
        send_cmd(tcct_pkg::CMD_BS, 8'h00, 8'h00, 8'h00);
        send_cmd(tcct_pkg::CMD_BS, 8'h00, 8'h00, 8'h00);
        send_cmd(tcct_pkg::CMD_BS, 8'h00, 8'h00, 8'h00);
        send_cmd(tcct_pkg::CMD_GLYPH, 8'h41, 8'h00, 8'h00);
        send_cmd(tcct_pkg::CMD_CR, 8'h00, 8'h00, 8'h00);
        send_cmd(tcct_pkg::CMD_NEWLINE, 8'h00, 8'h00, 8'h00);
        send_cmd(tcct_pkg::CMD_SET, 8'h00, 8'd79, 8'd24);
        send_cmd(tcct_pkg::CMD_GLYPH, 8'h5A, 8'h00, 8'h00);
        send_cmd(tcct_pkg::CMD_NEWLINE, 8'h00, 8'h00, 8'h00);
        send_cmd(tcct_pkg::CMD_SET, 8'h00, 8'hFF, 8'hFF);
        send_cmd(tcct_pkg::CMD_CLEAR, 8'h00, 8'h00, 8'h00);
        send_cmd(CMD_RSVD6, 8'hAA, 8'h55, 8'hAA);
        send_cmd(CMD_RSVD7, 8'h55, 8'hAA, 8'h55);
        drain_updates();
    endtask

    // not-ready console, one-cell lines and the largest console
    task automatic test_console_sizes();
        cfg_write(tcct_pkg::REG_COLUMNS, 8'd0);
        send_cmd(tcct_pkg::CMD_GLYPH, 8'h33, 8'h00, 8'h00);
        send_cmd(tcct_pkg::CMD_NEWLINE, 8'h00, 8'h00, 8'h00);
        send_cmd(tcct_pkg::CMD_BS, 8'h00, 8'h00, 8'h00);
        send_cmd(tcct_pkg::CMD_SET, 8'h00, 8'd5, 8'd5);
        drain_updates();
        cfg_write(tcct_pkg::REG_COLUMNS, 8'd1);
        send_cmd(tcct_pkg::CMD_GLYPH, 8'h21, 8'h00, 8'h00);
        send_cmd(tcct_pkg::CMD_NEWLINE, 8'h00, 8'h00, 8'h00);
        send_cmd(tcct_pkg::CMD_SET, 8'h00, 8'd200, 8'd200);
        send_cmd(tcct_pkg::CMD_GLYPH, 8'h7E, 8'h00, 8'h00);
        drain_updates();
        cfg_write(tcct_pkg::REG_COLUMNS, 8'd255);
        cfg_write(tcct_pkg::REG_ROWS, 8'd255);
        send_cmd(tcct_pkg::CMD_SET, 8'h00, 8'hFF, 8'hFF);
        send_cmd(tcct_pkg::CMD_GLYPH, 8'h80, 8'h00, 8'h00);
        send_cmd(tcct_pkg::CMD_BS, 8'h00, 8'h00, 8'h00);
        send_cmd(tcct_pkg::CMD_SET, 8'h00, 8'd254, 8'd0);
        send_cmd(tcct_pkg::CMD_BS, 8'h00, 8'h00, 8'h00);
        drain_updates();
        cfg_write(tcct_pkg::REG_ROWS, 8'd1);
        send_cmd(tcct_pkg::CMD_NEWLINE, 8'h00, 8'h00, 8'h00);
        drain_updates();
    endtask

    // receiver holds off while commands keep coming, so the input stalls
    task automatic test_stall_fill();
        cfg_write(tcct_pkg::REG_COLUMNS, 8'd6);
        cfg_write(tcct_pkg::REG_ROWS, 8'd3);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        hold_cycles = 60;
        repeat (30)
            send_cmd(tcct_pkg::CMD_GLYPH, 8'($urandom_range(0, 255)), 8'h00, 8'h00);
        drain_updates();
    endtask

    task automatic test_random_traffic();
        logic [7:0] c;
        logic [7:0] r;
        logic [7:0] tc;
        logic [7:0] tr;
        logic [2:0] op;
        int pick;
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: begin c = 8'd80;  r = 8'd25;  end
                1: begin c = 8'd1;   r = 8'd1;   end
                2: begin c = 8'd255; r = 8'd255; end
                3: begin c = 8'd0;   r = 8'd12;  end
                4: begin c = 8'd9;   r = 8'd0;   end
                5: begin c = 8'd3;   r = 8'd2;   end
                default:
                begin
                    c = 8'($urandom_range(1, 255));
                    r = 8'($urandom_range(1, 40));
                end
            endcase
            if ($urandom_range(0, 1) != 0)
            begin
                cfg_write(tcct_pkg::REG_COLUMNS, c);
                cfg_write(tcct_pkg::REG_ROWS, r);
            end
            else
            begin
                cfg_write(tcct_pkg::REG_ROWS, r);
                cfg_write(tcct_pkg::REG_COLUMNS, c);
            end
            for (int i = 0; i < 160; i++)
            begin
                if (i % 40 == 0)
                begin
                    tx_idle = $urandom_range(0, 2) != 0;
                    rx_idle = $urandom_range(0, 2) != 0;
                end
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    op = tcct_pkg::CMD_GLYPH;
                else if (pick < 57)
                    op = tcct_pkg::CMD_NEWLINE;
                else if (pick < 65)
                    op = tcct_pkg::CMD_CR;
                else if (pick < 77)
                    op = tcct_pkg::CMD_BS;
                else if (pick < 87)
                    op = tcct_pkg::CMD_SET;
                else if (pick < 92)
                    op = tcct_pkg::CMD_CLEAR;
                else
                    op = ($urandom_range(0, 1) != 0) ? CMD_RSVD6 : CMD_RSVD7;
                if ($urandom_range(0, 1) != 0)
                begin
                    tc = 8'($urandom_range(0, 255));
                    tr = 8'($urandom_range(0, 255));
                end
                else
                begin
                    tc = pred_cols + 8'($urandom_range(0, 3)) - 8'd2;
                    tr = pred_rows + 8'($urandom_range(0, 3)) - 8'd2;
                end
                send_cmd(op, 8'($urandom_range(0, 255)), tc, tr);
            end
            drain_updates();
        end
    endtask

    initial
    begin : update_receiver
        int gap;
        upd_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = rx_idle ? $urandom_range(0, 11) : 0;
            if (hold_cycles != 0)
            begin
                gap = hold_cycles;
                hold_cycles = 0;
            end
            if (gap != 0)
            begin
                upd_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            upd_ch.ready <= 1'b1;
            do @(posedge clk); while (!(upd_ch.valid && upd_ch.ready));
            @(negedge clk);
        end
    end

    initial
    begin : update_checker
        tcct_pkg::upd_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && upd_ch.valid && upd_ch.ready)
            begin
                if (pending_updates.size() == 0)
                begin
                    report_mismatch("unexpected update, action", upd_ch.action, 0);
                end
                else
                begin
                    want = pending_updates.pop_front();
                    if (upd_ch.action !== want.action)
                        report_mismatch("action", upd_ch.action, want.action);
                    if (upd_ch.cell_column !== want.cell_column)
                        report_mismatch("cell_column", upd_ch.cell_column, want.cell_column);
                    if (upd_ch.cell_row !== want.cell_row)
                        report_mismatch("cell_row", upd_ch.cell_row, want.cell_row);
                    if (upd_ch.glyph_out !== want.glyph_out)
                        report_mismatch("glyph_out", upd_ch.glyph_out, want.glyph_out);
                    if (upd_ch.scroll !== want.scroll)
                        report_mismatch("scroll", upd_ch.scroll, want.scroll);
                    if (upd_ch.nl_kind !== want.nl_kind)
                        report_mismatch("nl_kind", upd_ch.nl_kind, want.nl_kind);
                    if (upd_ch.nl_row !== want.nl_row)
                        report_mismatch("nl_row", upd_ch.nl_row, want.nl_row);
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("text_console_cursor_tracker_top: mismatch");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.command = '0;
        cmd_ch.glyph_in = '0;
        cmd_ch.target_column = '0;
        cmd_ch.target_row = '0;
        pred_cols = tcct_pkg::COLUMNS_RESET;
        pred_rows = tcct_pkg::ROWS_RESET;
        pred_col = '0;
        pred_row = '0;
        mismatch_count = 0;
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        hold_cycles = 0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        test_default_size();
        test_console_sizes();
        test_stall_fill();
        test_random_traffic();
        drain_updates();

        if (mismatch_count == 0)
            $display("text_console_cursor_tracker_top: match");
        else
            $display("text_console_cursor_tracker_top: mismatch");
        $finish;
    end
endmodule

@@ files.f @@
sv/tcct_pkg.sv
sv/tcct_if.sv
sv/tcct_step.sv
sv/text_console_cursor_tracker_top.sv
tb/tb_text_console_cursor_tracker_top.sv
